// File: sv/bsfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_pkg
// Shared types and constants of the byte-stuffed frame deframer.
// ----------------------------------------------------------------------------
package bsfd_pkg;

  localparam int CntW       = 10;
  localparam int ByteW      = 8;
  localparam int PayloadMax = 208 + 1 + 2;  // largest payload incl. cmd and crc
  localparam int LimitRst   = PayloadMax * 2 + 2;

  localparam logic [ByteW-1:0] StartDelim = 8'hC0;
  localparam logic [ByteW-1:0] EndDelim   = 8'hC1;
  localparam logic [ByteW-1:0] EscapeSym  = 8'h7D;
  localparam logic [ByteW-1:0] EscapeXor  = 8'h02;

  localparam logic [CntW-1:0] LimitReset = CntW'(LimitRst);

  typedef enum logic [0:0] {
    OpByte = 1'b0,
    OpDrop = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    KindData     = 3'd0,
    KindEnd      = 3'd1,
    KindEndEsc   = 3'd2,
    KindOverflow = 3'd3,
    KindDropped  = 3'd4
  } kind_e;

  typedef struct packed {
    opcode_e          opcode;
    logic [ByteW-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic [ByteW-1:0] data_byte;
    logic [CntW-1:0]  frame_length;
  } result_t;

endpackage

// File: sv/bsfd_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_regs
// APB register file holding the frame raw byte limit.
// ----------------------------------------------------------------------------
module bsfd_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [bsfd_pkg::CntW-1:0]  max_frame_bytes_o
);
  import bsfd_pkg::*;

  localparam logic RegMaxFrame = 1'b0;

  logic [CntW-1:0] max_q, max_d;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegMaxFrame);

  always_comb begin
    max_d = max_q;
    if (wr_en) begin
      max_d = pwdata[CntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= LimitReset;
    end else begin
      max_q <= max_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegMaxFrame) begin
      prdata = {{(32-CntW){1'b0}}, max_q};
    end
  end

  assign max_frame_bytes_o = max_q;

endmodule

// File: sv/bsfd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_core
// Frame state and per-byte unstuffing decision for one item.
// ----------------------------------------------------------------------------
module bsfd_core #(
  parameter int LimW = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  bsfd_pkg::item_t    item_i,
  input  logic [LimW-1:0]    limit_i,
  output bsfd_pkg::result_t  result_o
);
  import bsfd_pkg::*;

  logic            in_frame_q, in_frame_d;
  logic            esc_q, esc_d;
  logic [CntW-1:0] raw_q, raw_d;
  logic [CntW-1:0] dec_q, dec_d;
  logic            at_limit;

  assign at_limit = LimW'(raw_q) >= limit_i;

  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    raw_d      = raw_q;
    dec_d      = dec_q;
    result_o   = '{valid: 1'b0, kind: KindData, data_byte: '0, frame_length: '0};

    if (item_i.opcode == OpDrop) begin
      if (in_frame_q) begin
        result_o = '{valid: 1'b1, kind: KindDropped, data_byte: '0, frame_length: dec_q};
        in_frame_d = 1'b0;
        esc_d      = 1'b0;
        raw_d      = '0;
        dec_d      = '0;
      end
    end else if (!in_frame_q) begin
      // hunting: only the start delimiter opens a frame
      if (item_i.rx_byte == StartDelim) begin
        in_frame_d = 1'b1;
        esc_d      = 1'b0;
        raw_d      = '0;
        dec_d      = '0;
      end
    end else if (at_limit || item_i.rx_byte == EndDelim) begin
      if (at_limit) begin
        result_o.kind = KindOverflow;
      end else if (esc_q) begin
        result_o.kind = KindEndEsc;
      end else begin
        result_o.kind = KindEnd;
      end
      result_o.valid        = 1'b1;
      result_o.frame_length = dec_q;
      in_frame_d = 1'b0;
      esc_d      = 1'b0;
      raw_d      = '0;
      dec_d      = '0;
    end else begin
      raw_d = raw_q + 1'b1;
      if (esc_q) begin
        esc_d = 1'b0;
        dec_d = dec_q + 1'b1;
        result_o.valid     = 1'b1;
        result_o.data_byte = item_i.rx_byte ^ EscapeXor;
      end else if (item_i.rx_byte == EscapeSym) begin
        esc_d = 1'b1;
      end else begin
        dec_d = dec_q + 1'b1;
        result_o.valid     = 1'b1;
        result_o.data_byte = item_i.rx_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      raw_q      <= '0;
      dec_q      <= '0;
    end else if (advance_i) begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      raw_q      <= raw_d;
      dec_q      <= dec_d;
    end
  end

endmodule

// File: sv/byte_stuffed_frame_deframer_unit.sv
`timescale 1ns / 1ps
// latency: an input transfer is registered in the input stage, its result in the result register on the master side
// throughput: one byte per cycle while m_tready does not stall a held result, set by the frame state update
// bytes that give no result (idle bytes, escapes, start) still take one slot
// reset: asynchronous active low, hunting for start, limit register at 424
// ----------------------------------------------------------------------------
// byte_stuffed_frame_deframer_unit
// Streaming byte unstuffing deframer with delimiters, escapes and a raw limit.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_deframer_unit #(
  parameter int RAW_LIMIT_MAX = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  input  logic        s_tuser,   // opcode[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // data_byte[7:0], frame_length[17:8], zero[23:18]
  output logic [2:0]  m_tuser    // kind[2:0]
);
  import bsfd_pkg::*;

  localparam int RawLimW = $clog2(RAW_LIMIT_MAX + 1);
  localparam int LimW    = (RawLimW > CntW) ? RawLimW : CntW;

  logic [CntW-1:0] max_frame_bytes;
  logic [LimW-1:0] max_ext, limit;
  logic            in_valid_q, in_valid_d;
  item_t           item_q;
  logic            advance;
  result_t         result;
  logic            out_valid_q, out_valid_d;
  result_t         out_q;

  bsfd_regs u_regs (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .max_frame_bytes_o (max_frame_bytes)
  );

  assign max_ext = LimW'(max_frame_bytes);
  assign limit   = (max_ext > LimW'(RAW_LIMIT_MAX)) ? LimW'(RAW_LIMIT_MAX) : max_ext;

  // input stage moves on when the result register is free or being drained
  assign advance  = in_valid_q && (!out_valid_q || m_tready);
  assign s_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_tvalid && s_tready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid && s_tready) begin
      item_q <= '{opcode: opcode_e'(s_tuser), rx_byte: s_tdata};
    end
  end

  bsfd_core #(
    .LimW (LimW)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .limit_i   (limit),
    .result_o  (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = result.valid;
    end else if (m_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.valid) begin
      out_q <= result;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {6'b0, out_q.frame_length, out_q.data_byte};
  assign m_tuser  = out_q.kind;

  // a data byte never carries a length, and frame events never carry data
  a_data_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser == KindData |-> m_tdata[17:8] == '0)
    else $error("data transfer with nonzero frame length");

  a_event_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser != KindData |-> m_tdata[7:0] == '0)
    else $error("frame event with nonzero data byte");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready |-> in_valid_q && out_valid_q && !m_tready)
    else $error("input stalled without a blocked result");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_tready |=> out_valid_q && $stable(out_q))
    else $error("pending result changed while stalled");

endmodule

// File: sim/tb_byte_stuffed_frame_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_stuffed_frame_deframer_unit
// Self-checking bench for the byte unstuffing deframer. A queue-fed driver
// sends line bytes and drop commands. An in-bench unstuffing predictor tracks
// frame state and builds the expected output symbols. A monitor compares every
// output transfer field by field. Both sides idle at random. The frame limit
// register is rewritten between phases while the block is quiet.
// ----------------------------------------------------------------------------
module tb_byte_stuffed_frame_deframer_unit;
  import bsfd_pkg::*;

  localparam int          RawLimitMax = 1024;
  localparam int          DrainCycles = 8;
  localparam int          CycleLimit  = 400000;
  localparam int          RandTarget  = 1000;
  localparam logic [2:0]  LimitAddr   = 3'd0;

  typedef struct packed {
    opcode_e          op;
    logic [ByteW-1:0] rx;
  } line_item_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data_byte;
    logic [CntW-1:0]  frame_length;
  } deframed_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // rx_byte[7:0]
  logic        s_tuser  = 1'b0; // opcode[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // data_byte[7:0], frame_length[17:8], zero[23:18]
  logic [2:0]  m_tuser;         // kind[2:0]

  byte_stuffed_frame_deframer_unit #(
    .RAW_LIMIT_MAX(RawLimitMax)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #2 clk_i = ~clk_i;

  // predictor state, mirrors the block after reset
  logic [CntW-1:0] limit_m   = LimitReset;
  bit              in_frame_m = 1'b0;
  bit              esc_m      = 1'b0;
  logic [CntW-1:0] raw_m      = '0;
  logic [CntW-1:0] dec_m      = '0;

  line_item_t  line_q[$];
  deframed_t   unstuffed_q[$];
  int          errors      = 0;
  int          cycles      = 0;
  int          n_in        = 0;
  int          n_out       = 0;
  int          n_pushed    = 0;
  int          n_noise     = 0;
  int          n_settings  = 0;
  int          kind_seen[5];
  bit          tx_eager    = 1'b0;
  bit          rx_eager    = 1'b0;
  int          gap_cnt     = 0;
  int          stall_cnt   = 0;

  function automatic void close_frame();
    in_frame_m = 1'b0;
    esc_m      = 1'b0;
    raw_m      = '0;
    dec_m      = '0;
  endfunction

  // unstuff one line item; returns 1 when it yields an output symbol
  function automatic bit unstuff(input opcode_e op, input logic [ByteW-1:0] b,
                                 output deframed_t r);
    int unsigned lim;
    lim = (int'(limit_m) > RawLimitMax) ? RawLimitMax : int'(limit_m);
    r = '{kind: KindData, data_byte: '0, frame_length: '0};
    if (op == OpDrop) begin
      if (!in_frame_m) return 1'b0;
      r.kind         = KindDropped;
      r.frame_length = dec_m;
      close_frame();
      return 1'b1;
    end
    if (!in_frame_m) begin
      if (b == StartDelim) begin
        close_frame();
        in_frame_m = 1'b1;
      end
      return 1'b0;
    end
    if (int'(raw_m) >= lim) begin
      r.kind         = KindOverflow;
      r.frame_length = dec_m;
      close_frame();
      return 1'b1;
    end
    if (b == EndDelim) begin
      r.kind         = esc_m ? KindEndEsc : KindEnd;
      r.frame_length = dec_m;
      close_frame();
      return 1'b1;
    end
    raw_m = raw_m + 1'b1;
    if (esc_m) begin
      esc_m       = 1'b0;
      dec_m       = dec_m + 1'b1;
      r.data_byte = b ^ EscapeXor;
      return 1'b1;
    end
    if (b == EscapeSym) begin
      esc_m = 1'b1;
      return 1'b0;
    end
    dec_m       = dec_m + 1'b1;
    r.data_byte = b;
    return 1'b1;
  endfunction

  // driver: one item per transfer, random gap after each unless tx_eager is set
  deframed_t  tx_exp;
  line_item_t tx_next;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      gap_cnt  <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        n_in++;
        if (unstuff(opcode_e'(s_tuser), s_tdata, tx_exp)) unstuffed_q.push_back(tx_exp);
      end
      if (s_tvalid && !s_tready) begin
        // hold the item until it is taken
      end else if (gap_cnt > 0) begin
        s_tvalid <= 1'b0;
        gap_cnt  <= gap_cnt - 1;
      end else if (line_q.size() > 0) begin
        tx_next  = line_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= tx_next.op;
        s_tdata  <= tx_next.rx;
        gap_cnt  <= tx_eager ? 0 : $urandom_range(0, 9);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor: checks each output transfer against the oldest prediction
  deframed_t want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready  <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_out++;
        if (m_tuser < 3'd5) kind_seen[m_tuser]++;
        if (unstuffed_q.size() == 0) begin
          $error("unexpected transfer: kind %0d tdata 0x%06h", m_tuser, m_tdata);
          errors++;
        end else begin
          want = unstuffed_q.pop_front();
          if (m_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, m_tuser);
            errors++;
          end
          if (m_tdata[7:0] !== want.data_byte) begin
            $error("data_byte: expected 0x%02h, got 0x%02h", want.data_byte, m_tdata[7:0]);
            errors++;
          end
          if (m_tdata[17:8] !== want.frame_length) begin
            $error("frame_length: expected %0d, got %0d", want.frame_length, m_tdata[17:8]);
            errors++;
          end
          if (m_tdata[23:18] !== 6'd0) begin
            $error("tdata padding: expected 0, got 0x%02h", m_tdata[23:18]);
            errors++;
          end
        end
      end
      if (stall_cnt > 0) begin
        m_tready  <= 1'b0;
        stall_cnt <= stall_cnt - 1;
      end else begin
        m_tready <= 1'b1;
        if (m_tvalid && m_tready) stall_cnt <= rx_eager ? 0 : $urandom_range(0, 9);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_byte_stuffed_frame_deframer_unit: errors");
      $finish;
    end
  end

  task automatic push_item(input opcode_e op, input logic [7:0] b);
    line_q.push_back('{op: op, rx: b});
    n_pushed++;
  endtask

  task automatic rx(input logic [7:0] b);
    push_item(OpByte, b);
  endtask

  task automatic drop();
    push_item(OpDrop, 8'($urandom_range(0, 255)));
  endtask

  // wait until every queued item is taken and every expected transfer is seen
  task automatic settle();
    while (n_in != n_pushed || unstuffed_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= LimitAddr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_limit(input logic [CntW-1:0] lim);
    logic [31:0] rd;
    apb_access(1'b1, 32'(lim), rd);
    limit_m = lim;
    n_settings++;
    apb_access(1'b0, '0, rd);
    if (rd !== 32'(lim)) begin
      $error("max_frame_bytes readback: expected %0d, got %0d", lim, rd);
      errors++;
    end
  endtask

  // frame with random content, biased toward the special bytes; it may end in a drop or a dangling escape, or stay open
  task automatic push_frame(input int len);
    logic [7:0] b;
    int         sel;
    rx(StartDelim);
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(0, 15);
      case (sel)
        0:       b = StartDelim;
        1:       b = EndDelim;
        2:       b = EscapeSym;
        3:       b = 8'h00;
        4:       b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      if (b == EndDelim || b == EscapeSym || $urandom_range(0, 7) == 0) begin
        rx(EscapeSym);
        rx(b ^ EscapeXor);
      end else begin
        rx(b);
      end
      if ($urandom_range(0, 59) == 0) begin
        drop();
        return;
      end
    end
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      rx(EndDelim);
    end else if (sel == 7) begin
      rx(EscapeSym);
      rx(EndDelim);
    end else if (sel == 8) begin
      drop();
    end
    // else left open; whatever follows lands inside the frame
  endtask

  task automatic push_noise(input int cnt);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 3) == 0) drop();
      else rx(8'($urandom_range(0, 255)));
      n_noise++;
    end
  endtask

  initial begin
    int phase;
    int start_cnt;
    int len;
    logic [31:0] rd;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    apb_access(1'b0, '0, rd);
    if (rd !== 32'(LimitReset)) begin
      $error("max_frame_bytes after reset: expected %0d, got %0d", LimitReset, rd);
      errors++;
    end

    // idle bytes and a drop while hunting: nothing comes out
    rx(8'h00); rx(8'hFF); rx(EndDelim); rx(EscapeSym); drop();
    // frame with extremes, a stray start, escaped bytes and escaped escape
    rx(StartDelim); rx(8'h00); rx(8'hFF); rx(StartDelim);
    rx(EscapeSym); rx(8'h5E); rx(EscapeSym); rx(EscapeSym);
    rx(EscapeSym); rx(8'hC3); rx(EndDelim);
    // dangling escape, drop in frame, empty frame
    rx(StartDelim); rx(8'h12); rx(EscapeSym); rx(EndDelim);
    rx(StartDelim); rx(8'h34); drop();
    rx(StartDelim); rx(EndDelim);
    settle();

    // limit reached: a plain byte, then an end delimiter, both abort
    set_limit(10'd2);
    rx(StartDelim); rx(8'hAA); rx(8'hBB); rx(8'hCC);
    rx(StartDelim); rx(8'h11); rx(8'h22); rx(EndDelim);
    settle();
    // limit zero aborts on the first byte after start
    set_limit(10'd0);
    rx(StartDelim); rx(8'h55);
    settle();
    set_limit(10'd1);
    rx(StartDelim); rx(EscapeSym); rx(8'h44); rx(EndDelim);
    settle();

    start_cnt = n_pushed;
    phase = 0;
    while (n_pushed - start_cnt < RandTarget) begin
      case (phase)
        0:       set_limit(10'd1023);
        1:       set_limit(10'd1);
        2:       set_limit(LimitReset);
        default: set_limit((phase % 3 == 0) ? 10'd1023 : 10'($urandom_range(1, 40)));
      endcase
      tx_eager = ($urandom_range(0, 2) == 0);
      rx_eager = ($urandom_range(0, 2) == 0);
      len = n_pushed;
      while (n_pushed - len < 150 && n_pushed - start_cnt < RandTarget) begin
        if ($urandom_range(0, 4) == 0) push_noise($urandom_range(1, 6));
        else push_frame(($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(0, 16));
      end
      // close whatever frame is left open so the next limit starts clean
      drop();
      settle();
      phase++;
    end

    if (unstuffed_q.size() != 0) begin
      $error("%0d expected transfers never arrived", unstuffed_q.size());
      errors++;
    end
    $display("run covered %0d input transfers (%0d noise) and %0d output transfers over %0d limit settings",
             n_in, n_noise, n_out, n_settings);
    $display("outputs: %0d data, %0d ends, %0d dangling escapes, %0d overflows, %0d drops",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (errors == 0) begin
      $display("tb_byte_stuffed_frame_deframer_unit: clean");
    end else begin
      $display("tb_byte_stuffed_frame_deframer_unit: errors");
    end
    $finish;
  end

endmodule
